FILE: rtl/markup_aware_word_search_macros.svh
// Assertion macros used by the markup-aware word search top level.
`ifndef MARKUP_AWARE_WORD_SEARCH_MACROS_SVH
`define MARKUP_AWARE_WORD_SEARCH_MACROS_SVH

// Same-cycle implication, checked on every rising aclk outside reset.
`define MAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising aclk outside reset.
`define MAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mas_pkg.sv
// Package: types, constants and helper functions of the markup-aware word search.
`timescale 1ns / 1ps
package mas_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int POS_W       = $clog2(MAX_PATTERN) + 1;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;

    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,
        MODE_WORD   = 4'b0010,
        MODE_TAG    = 4'b0100,
        MODE_STRING = 4'b1000
    } scan_mode_t;

    typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

    typedef struct packed {
        scan_mode_t       mode;
        scan_mode_t       mode_before_quote;
        logic             quote_is_double;
        logic [POS_W-1:0] position;
        logic             pending;
        logic             found;
    } scan_state_t;

    localparam scan_state_t SCAN_STATE_RESET = '{
        mode:              MODE_START,
        mode_before_quote: MODE_START,
        quote_is_double:   1'b0,
        position:          '0,
        pending:           1'b0,
        found:             1'b0
    };

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

endpackage

FILE: rtl/mas_cfg_regs.sv
// Configuration registers: pattern bytes and pattern length.
`timescale 1ns / 1ps
module mas_cfg_regs
    import mas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pattern_t              pattern,
    output logic [LEN_W-1:0]      pattern_length
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            length_reg       <= LEN_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pattern_low_reg  <= cfg_wdata;
                CFG_PATTERN_HIGH: pattern_high_reg <= cfg_wdata;
                CFG_PATTERN_LEN:  length_reg       <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern        = pattern_t'({pattern_high_reg, pattern_low_reg});
    assign pattern_length = length_reg;

endmodule

FILE: rtl/mas_scan_step.sv
// Per-byte scanner update: mode tracking, pattern compare and match confirmation.
`timescale 1ns / 1ps
module mas_scan_step
    import mas_pkg::*;
(
    input  scan_state_t       state,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  pattern_t          pattern,
    input  logic [LEN_W-1:0]  pattern_length,
    output scan_state_t       state_next,
    output logic              match_now,
    output logic              found_so_far
);

    logic [7:0]       c;
    logic             is_quote;
    logic             is_double;
    logic             raw_alnum;
    logic [LEN_W-1:0] used_len;
    logic [POS_W-1:0] pos_inc;
    logic             hit;
    scan_state_t      upd;

    always_comb begin
        c         = to_lower(data_byte);
        is_quote  = (c == CHAR_SQUOTE) || (c == CHAR_DQUOTE);
        is_double = (c == CHAR_DQUOTE);
        raw_alnum = is_alnum(data_byte);
        pos_inc   = state.position + POS_W'(1);

        // clamp length into 1..MAX_PATTERN
        if (pattern_length == '0) begin
            used_len = LEN_W'(1);
        end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
            used_len = LEN_W'(MAX_PATTERN);
        end else begin
            used_len = pattern_length;
        end

        hit         = state.pending && !raw_alnum;
        upd         = state;
        upd.pending = 1'b0;

        if (state.mode == MODE_STRING && is_quote) begin
            if (is_double == state.quote_is_double) begin
                upd.mode = state.mode_before_quote;
            end
        end else if (is_quote) begin
            upd.mode_before_quote = state.mode;
            upd.quote_is_double   = is_double;
            upd.mode              = MODE_STRING;
        end else if (c == CHAR_LT) begin
            upd.mode = MODE_TAG;
        end else begin
            unique case (state.mode)
                MODE_TAG: begin
                    if (c == CHAR_GT) begin
                        upd.mode = MODE_START;
                    end
                end
                MODE_WORD: begin
                    if (!raw_alnum) begin
                        upd.mode = MODE_START;
                    end
                end
                MODE_START: begin
                    if (pattern[state.position[IDX_W-1:0]] == c) begin
                        if (LEN_W'(pos_inc) >= used_len) begin
                            upd.position = '0;
                            if (last_byte) begin
                                hit = 1'b1;
                            end else begin
                                upd.pending = 1'b1;
                            end
                        end else begin
                            upd.position = pos_inc;
                        end
                    end else begin
                        upd.position = '0;
                        upd.mode     = raw_alnum ? MODE_WORD : MODE_START;
                    end
                end
                MODE_STRING: ;
                default: ;
            endcase
        end

        upd.found    = state.found | hit;
        match_now    = hit;
        found_so_far = upd.found;
        // end of scan: drop all state
        state_next   = last_byte ? SCAN_STATE_RESET : upd;
    end

endmodule

FILE: rtl/markup_aware_word_search.sv
// Markup-aware whole-word search: top level with input and result registers.
//
// Usage: bytes of markup text enter on the s_ stream (s_tdata = byte, s_tlast marks
// the final byte of a scan). One result item leaves on the m_ stream per input item:
// m_tdata[0] = match_now, m_tdata[1] = found_so_far, m_tlast = scan_done.
// A match of the configured pattern is reported on the byte after it completes,
// once that byte is seen to be non-alphanumeric, or on the completing byte itself
// when it carries s_tlast. Text inside <...> tags and quoted strings is skipped.
// The item sits in the input register and moves into the result register once that
// register is free. Throughput: one item per cycle while m_tready stays high; the
// scanner state loop runs through the byte classifier and one pattern byte compare.
// Stalls: when m_tready is low the result register holds, the input register
// still takes one more item, and s_tready then drops until the result drains.
// Reset (aresetn low, synchronous) empties both registers, returns the scanner to
// word start and sets the pattern to all zeros with length 1. Write the pattern
// registers through cfg_we/cfg_index/cfg_wdata only while no item is in flight.
`timescale 1ns / 1ps
`include "markup_aware_word_search_macros.svh"
module markup_aware_word_search
    import mas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] match_now, [1] found_so_far, [7:2] zero
    output logic                  m_tlast,   // scan_done
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pattern_t         pattern;
    logic [LEN_W-1:0] pattern_length;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    scan_state_t      state_reg;
    scan_state_t      state_next;
    logic             match_next;
    logic             found_next;

    logic             out_valid_reg;
    logic             out_match_reg;
    logic             out_found_reg;
    logic             out_last_reg;

    logic             advance;

    mas_cfg_regs u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .pattern        (pattern),
        .pattern_length (pattern_length)
    );

    mas_scan_step u_step (
        .state          (state_reg),
        .data_byte      (in_byte_reg),
        .last_byte      (in_last_reg),
        .pattern        (pattern),
        .pattern_length (pattern_length),
        .state_next     (state_next),
        .match_now      (match_next),
        .found_so_far   (found_next)
    );

    // move the held item into the result register when that register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_match_reg <= match_next;
            out_found_reg <= found_next;
            out_last_reg  <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_found_reg, out_match_reg};
    assign m_tlast  = out_last_reg;

    `MAS_ASSERT_NOW(a_match_sets_found, out_valid_reg && out_match_reg, out_found_reg,
        "match_now without found_so_far")
    `MAS_ASSERT_NEXT(a_scan_end_clears, advance && in_last_reg,
        state_reg == SCAN_STATE_RESET, "state not cleared after last byte")
    `MAS_ASSERT_NOW(a_pending_at_start, state_reg.pending, state_reg.mode == MODE_START,
        "match pending outside word start")
    `MAS_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_tready,
        "input stalled with empty input register")

endmodule
